@@ hw/rtl/stc_pkg.sv @@
// stc_pkg: shared types and codes for the symbol table block
// fsm state type, controller/datapath command and status structs, kind and status codes
// no dependencies
package stc_pkg;

    localparam int KIND_W      = 3;
    localparam int LABEL_W     = 64;
    localparam int SYM_W       = 64;
    localparam int ADDR_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MOD_LABEL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_MOD_ADDR   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MOD_BOTH   = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
        logic result;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

@@ hw/rtl/symbol_table_cam.sv @@
// symbol_table_cam: ordered label/symbol/address table, one request at a time
// a request is accepted in idle, the table is scanned, the result is finished and then registered for output;
// a new request is taken only once the result has been placed in the output register;
// one table entry is read per cycle through the single read port of the table ram
// reset: entry count and handshake state clear on a synchronous reset; table contents are not cleared
// depends on stc_pkg, stc_ctrl, stc_dpath, stc_ram
module symbol_table_cam #(
    parameter int TABLE_DEPTH = 16,
    parameter int LABEL_CHARS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [stc_pkg::KIND_W-1:0]        i_kind,
    input  logic [stc_pkg::LABEL_W-1:0]       i_key_label,
    input  logic [stc_pkg::SYM_W-1:0]         i_entry_symbol,
    input  logic [stc_pkg::ADDR_W-1:0]        i_entry_address,
    input  logic [stc_pkg::LABEL_W-1:0]       i_replacement_label,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [stc_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_found,
    output logic [stc_pkg::COUNT_OUT_W-1:0]   o_entry_count
);

    stc_pkg::t_cmd cmd;
    stc_pkg::t_sts sts;

    stc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    stc_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .LABEL_CHARS (LABEL_CHARS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_kind              (i_kind),
        .i_key_label         (i_key_label),
        .i_entry_symbol      (i_entry_symbol),
        .i_entry_address     (i_entry_address),
        .i_replacement_label (i_replacement_label),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_found             (o_found),
        .o_entry_count       (o_entry_count)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again while a request is in progress");

    a_scan_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> cmd.scan)
        else $error("scan did not start after accept");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.result |-> (!o_out_valid || i_out_ready))
        else $error("result overwrote an item not yet taken");

    a_result_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> !o_in_ready)
        else $error("ready before result was delivered");

endmodule

@@ hw/rtl/stc_ram.sv @@
// stc_ram: generic single write port, single read port ram with registered read
// no dependencies
module stc_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/stc_ctrl.sv @@
// stc_ctrl: request sequencer for the symbol table
// depends on stc_pkg (state, command and status types)
module stc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  stc_pkg::t_sts i_sts,
    output stc_pkg::t_cmd o_cmd
);

    stc_pkg::t_state r_state;
    stc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            stc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = stc_pkg::S_SCAN;
                end
            end
            stc_pkg::S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = stc_pkg::S_FINISH;
                end
            end
            stc_pkg::S_FINISH: begin
                n_state = stc_pkg::S_DONE;
            end
            stc_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = stc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            stc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            stc_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            stc_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
            end
            stc_pkg::S_DONE: begin
                o_cmd.result = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/stc_dpath.sv @@
// stc_dpath: table ram, scan pipeline, entry count and result register
// depends on stc_pkg (codes, command and status types) and stc_ram
module stc_dpath #(
    parameter int TABLE_DEPTH = 16,
    parameter int LABEL_CHARS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  stc_pkg::t_cmd                     i_cmd,
    output stc_pkg::t_sts                     o_sts,
    input  logic [stc_pkg::KIND_W-1:0]        i_kind,
    input  logic [stc_pkg::LABEL_W-1:0]       i_key_label,
    input  logic [stc_pkg::SYM_W-1:0]         i_entry_symbol,
    input  logic [stc_pkg::ADDR_W-1:0]        i_entry_address,
    input  logic [stc_pkg::LABEL_W-1:0]       i_replacement_label,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [stc_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_found,
    output logic [stc_pkg::COUNT_OUT_W-1:0]   o_entry_count
);

    localparam int LBITS = LABEL_CHARS * 8;
    localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int RAM_W = LBITS + stc_pkg::SYM_W + stc_pkg::ADDR_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [stc_pkg::KIND_W-1:0]   r_kind;
    logic [LBITS-1:0]             r_key;
    logic [stc_pkg::SYM_W-1:0]    r_sym;
    logic [stc_pkg::ADDR_W-1:0]   r_addr;
    logic [LBITS-1:0]             r_newlab;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic [CW-1:0]                r_rd_idx;
    logic                         r_cmp_vld;
    logic [IW-1:0]                r_cmp_idx;
    logic                         r_hit;
    logic [stc_pkg::STATUS_W-1:0] r_res_status;
    logic [stc_pkg::STATUS_W-1:0] n_res_status;
    logic                         r_out_valid;
    logic [stc_pkg::STATUS_W-1:0] r_out_status;
    logic                         r_out_found;
    logic [CW-1:0]                r_out_count;

    logic                         rd_en;
    logic [RAM_W-1:0]             rd_data;
    logic [LBITS-1:0]             rd_label;
    logic [stc_pkg::SYM_W-1:0]    rd_sym;
    logic [stc_pkg::ADDR_W-1:0]   rd_addr;
    logic                         match;
    logic                         is_modify;
    logic                         is_delete;
    logic                         full;
    logic                         do_insert;
    logic                         we;
    logic [IW-1:0]                waddr;
    logic [RAM_W-1:0]             wdata;
    logic [LBITS-1:0]             mod_label;
    logic [stc_pkg::ADDR_W-1:0]   mod_addr;

    assign rd_label  = rd_data[RAM_W-1 -: LBITS];
    assign rd_sym    = rd_data[stc_pkg::ADDR_W +: stc_pkg::SYM_W];
    assign rd_addr   = rd_data[stc_pkg::ADDR_W-1:0];
    assign rd_en     = i_cmd.scan && (r_rd_idx < r_count);
    assign match     = r_cmp_vld && (rd_label == r_key);
    assign is_modify = (r_kind == stc_pkg::KIND_MOD_LABEL) || (r_kind == stc_pkg::KIND_MOD_ADDR)
                    || (r_kind == stc_pkg::KIND_MOD_BOTH);
    assign is_delete = (r_kind == stc_pkg::KIND_DELETE);
    assign full      = (r_count == DEPTH_C);
    assign do_insert = (r_kind == stc_pkg::KIND_INSERT) && !r_hit && !full;
    assign mod_label = (r_kind != stc_pkg::KIND_MOD_ADDR) ? r_newlab : rd_label;
    assign mod_addr  = (r_kind != stc_pkg::KIND_MOD_LABEL) ? r_addr : rd_addr;

    // modify rewrites matches in place, delete shifts entries after the first match down, insert appends at the end
    always_comb begin
        we    = 1'b0;
        waddr = r_cmp_idx;
        wdata = rd_data;
        if (is_modify && match) begin
            we    = 1'b1;
            wdata = {mod_label, rd_sym, mod_addr};
        end else if (is_delete && r_cmp_vld && r_hit) begin
            we    = 1'b1;
            waddr = r_cmp_idx - IW'(1);
        end else if (i_cmd.finish && do_insert) begin
            we    = 1'b1;
            waddr = r_count[IW-1:0];
            wdata = {r_key, r_sym, r_addr};
        end
    end

    stc_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[IW-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_count      = r_count;
        n_res_status = stc_pkg::STATUS_OK;
        case (r_kind)
            stc_pkg::KIND_INSERT: begin
                if (r_hit) begin
                    n_res_status = stc_pkg::STATUS_DUPLICATE;
                end else if (full) begin
                    n_res_status = stc_pkg::STATUS_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            stc_pkg::KIND_DELETE: begin
                if (r_hit) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_res_status = stc_pkg::STATUS_NOT_FOUND;
                end
            end
            stc_pkg::KIND_SEARCH, stc_pkg::KIND_MOD_LABEL, stc_pkg::KIND_MOD_ADDR,
            stc_pkg::KIND_MOD_BOTH: begin
                if (!r_hit) begin
                    n_res_status = stc_pkg::STATUS_NOT_FOUND;
                end
            end
            default: begin
                n_res_status = stc_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= rd_en;
            end
            if (i_cmd.finish) begin
                r_count <= n_count;
            end
            if (i_cmd.result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_key    <= i_key_label[LBITS-1:0];
            r_sym    <= i_entry_symbol;
            r_addr   <= i_entry_address;
            r_newlab <= i_replacement_label[LBITS-1:0];
            r_rd_idx <= '0;
            r_hit    <= 1'b0;
        end else if (i_cmd.scan) begin
            if (rd_en) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            r_cmp_idx <= r_rd_idx[IW-1:0];
            r_hit     <= r_hit | match;
        end
        if (i_cmd.finish) begin
            r_res_status <= n_res_status;
        end
        if (i_cmd.result) begin
            r_out_status <= r_res_status;
            r_out_found  <= r_hit;
            r_out_count  <= r_count;
        end
    end

    assign o_sts.scan_done = (r_rd_idx == r_count) && !r_cmp_vld;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found       = r_out_found;
    assign o_entry_count = stc_pkg::COUNT_OUT_W'(r_out_count);

endmodule

@@ dv/tb.sv @@
// tb: self-checking bench for symbol_table_cam, driving requests and checking each reply
// against a behavioral table model kept in the bench; depends on stc_pkg and symbol_table_cam
`timescale 1ns / 1ps

module tb;
    import stc_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int LABEL_CHARS = 8;
    localparam logic [LABEL_W-1:0] LABEL_MASK =
        (LABEL_CHARS >= 8) ? '1 : ((64'd1 << (8 * LABEL_CHARS)) - 64'd1);
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
    localparam int LABEL_POOL = 24;
    localparam int ITEMS_PER_PHASE = 420;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [LABEL_W-1:0] key;
        logic [SYM_W-1:0]   sym;
        logic [ADDR_W-1:0]  addr;
        logic [LABEL_W-1:0] newlab;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   found;
        logic [COUNT_OUT_W-1:0] count;
    } t_reply;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [KIND_W-1:0]      i_kind = '0;
    logic [LABEL_W-1:0]     i_key_label = '0;
    logic [SYM_W-1:0]       i_entry_symbol = '0;
    logic [ADDR_W-1:0]      i_entry_address = '0;
    logic [LABEL_W-1:0]     i_replacement_label = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic                   o_found;
    logic [COUNT_OUT_W-1:0] o_entry_count;

    logic [LABEL_W-1:0] tbl_label [TABLE_DEPTH];
    logic [SYM_W-1:0]   tbl_symbol [TABLE_DEPTH];
    logic [ADDR_W-1:0]  tbl_addr [TABLE_DEPTH];
    int                 tbl_count = 0;

    logic [LABEL_W-1:0] label_pool [LABEL_POOL];
    t_request pending_requests [$];
    t_reply   expected_replies [$];
    logic     in_taken = 1'b0;
    int       sender_idle_pct = 0;
    int       receiver_stall_pct = 0;
    int       hold_requests = 0;
    int       holds_served = 0;
    int       hold_left = 0;
    int       error_count = 0;
    int       cycle_count = 0;

    symbol_table_cam #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .LABEL_CHARS(LABEL_CHARS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_kind(i_kind),
        .i_key_label(i_key_label),
        .i_entry_symbol(i_entry_symbol),
        .i_entry_address(i_entry_address),
        .i_replacement_label(i_replacement_label),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_found(o_found),
        .o_entry_count(o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_reply apply_request(t_request rq);
        logic [LABEL_W-1:0] key;
        logic [LABEL_W-1:0] newlab;
        logic               hit;
        int                 first;
        t_reply             rp;
        key = rq.key & LABEL_MASK;
        newlab = rq.newlab & LABEL_MASK;
        hit = 1'b0;
        first = 0;
        rp.status = STATUS_OK;
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_label[i] == key) begin
                if (!hit) first = i;
                hit = 1'b1;
            end
        end
        case (rq.kind)
            KIND_INSERT: begin
                if (hit) begin
                    rp.status = STATUS_DUPLICATE;
                end else if (tbl_count >= TABLE_DEPTH) begin
                    rp.status = STATUS_FULL;
                end else begin
                    tbl_label[tbl_count] = key;
                    tbl_symbol[tbl_count] = rq.sym;
                    tbl_addr[tbl_count] = rq.addr;
                    tbl_count++;
                end
            end
            KIND_DELETE: begin
                if (!hit) begin
                    rp.status = STATUS_NOT_FOUND;
                end else begin
                    for (int i = first; i + 1 < tbl_count; i++) begin
                        tbl_label[i] = tbl_label[i + 1];
                        tbl_symbol[i] = tbl_symbol[i + 1];
                        tbl_addr[i] = tbl_addr[i + 1];
                    end
                    tbl_count--;
                end
            end
            KIND_SEARCH: begin
                rp.status = hit ? STATUS_OK : STATUS_NOT_FOUND;
            end
            KIND_MOD_LABEL, KIND_MOD_ADDR, KIND_MOD_BOTH: begin
                if (!hit) begin
                    rp.status = STATUS_NOT_FOUND;
                end else begin
                    for (int i = 0; i < tbl_count; i++) begin
                        if (tbl_label[i] == key) begin
                            if (rq.kind != KIND_MOD_LABEL) tbl_addr[i] = rq.addr;
                            if (rq.kind != KIND_MOD_ADDR) tbl_label[i] = newlab;
                        end
                    end
                end
            end
            default: rp.status = STATUS_OK;
        endcase
        rp.found = hit;
        rp.count = tbl_count[COUNT_OUT_W-1:0];
        return rp;
    endfunction

    function automatic logic [LABEL_W-1:0] pick_label();
        if ($urandom_range(99) < 8) return {$urandom, $urandom};
        return label_pool[$urandom_range(LABEL_POOL - 1)];
    endfunction

    function automatic t_request make_request(logic insert_heavy);
        t_request rq;
        int       r;
        r = $urandom_range(99);
        if (insert_heavy) begin
            if (r < 55) rq.kind = KIND_INSERT;
            else if (r < 65) rq.kind = KIND_DELETE;
            else if (r < 78) rq.kind = KIND_SEARCH;
            else if (r < 84) rq.kind = KIND_MOD_LABEL;
            else if (r < 90) rq.kind = KIND_MOD_ADDR;
            else if (r < 96) rq.kind = KIND_MOD_BOTH;
            else rq.kind = r[0] ? KIND_SPARE_A : KIND_SPARE_B;
        end else begin
            if (r < 20) rq.kind = KIND_INSERT;
            else if (r < 55) rq.kind = KIND_DELETE;
            else if (r < 70) rq.kind = KIND_SEARCH;
            else if (r < 80) rq.kind = KIND_MOD_LABEL;
            else if (r < 88) rq.kind = KIND_MOD_ADDR;
            else if (r < 96) rq.kind = KIND_MOD_BOTH;
            else rq.kind = r[0] ? KIND_SPARE_A : KIND_SPARE_B;
        end
        rq.key = pick_label();
        rq.sym = {$urandom, $urandom};
        r = $urandom_range(9);
        rq.addr = (r == 0) ? '0 : (r == 1) ? '1 : ADDR_W'($urandom);
        rq.newlab = pick_label();
        return rq;
    endfunction

    task automatic push_request(logic [KIND_W-1:0] kind, logic [LABEL_W-1:0] key,
                                logic [SYM_W-1:0] sym, logic [ADDR_W-1:0] addr,
                                logic [LABEL_W-1:0] newlab);
        t_request rq;
        rq.kind = kind;
        rq.key = key;
        rq.sym = sym;
        rq.addr = addr;
        rq.newlab = newlab;
        pending_requests.push_back(rq);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || i_in_valid || expected_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // request driver
    always @(negedge i_clk) begin
        t_request rq;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                rq = pending_requests.pop_front();
                i_kind <= rq.kind;
                i_key_label <= rq.key;
                i_entry_symbol <= rq.sym;
                i_entry_address <= rq.addr;
                i_replacement_label <= rq.newlab;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // reply receiver, with a single long hold-off requested in the first random phase
    always @(negedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // monitor: predict on each accepted item, check each accepted reply
    always @(posedge i_clk) begin
        t_reply want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                expected_replies.push_back(apply_request({i_kind, i_key_label, i_entry_symbol,
                                                          i_entry_address,
                                                          i_replacement_label}));
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected reply status %0d found %0d count %0d",
                             $time, o_status, o_found, o_entry_count);
                    error_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, o_status);
                        error_count++;
                    end
                    if (o_found !== want.found) begin
                        $display("%0t: found expected %0d got %0d",
                                 $time, want.found, o_found);
                        error_count++;
                    end
                    if (o_entry_count !== want.count) begin
                        $display("%0t: entry count expected %0d got %0d",
                                 $time, want.count, o_entry_count);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        logic insert_heavy;
        int    len;
        label_pool[0] = '0;
        label_pool[1] = '1;
        for (int i = 2; i < LABEL_POOL; i++) begin
            if (i % 3 == 0) begin
                label_pool[i] = {$urandom, $urandom};
            end else begin
                label_pool[i] = '0;
                len = $urandom_range(1, 8);
                for (int c = 0; c < len; c++)
                    label_pool[i][8*c +: 8] = 8'($urandom_range(97, 122));
            end
        end

        // empty table, extremes, duplicates and spare kinds
        push_request(KIND_SEARCH, '0, '0, '0, '0);
        push_request(KIND_DELETE, '1, '0, '0, '0);
        push_request(KIND_MOD_LABEL, '0, '0, '0, '1);
        push_request(KIND_MOD_BOTH, '1, '0, '1, '0);
        push_request(KIND_INSERT, '0, '0, '0, '0);
        push_request(KIND_INSERT, '1, '1, '1, '1);
        push_request(KIND_INSERT, '0, '1, '1, '1);
        push_request(KIND_SEARCH, '1, '0, '0, '0);
        push_request(KIND_INSERT, 64'h41, 64'h42, 16'h1234, '0);
        // duplicate the last label, then delete must drop the earliest only
        push_request(KIND_MOD_LABEL, '1, '0, '0, 64'h41);
        push_request(KIND_DELETE, 64'h41, '0, '0, '0);
        push_request(KIND_SEARCH, 64'h41, '0, '0, '0);
        push_request(KIND_MOD_ADDR, '0, '0, '1, '1);
        push_request(KIND_MOD_BOTH, 64'h41, '0, '0, '1);
        push_request(KIND_SPARE_A, '1, '0, '0, '0);
        push_request(KIND_SPARE_B, 64'h5a5a, '0, '0, '0);
        push_request(KIND_DELETE, '0, '0, '0, '0);
        push_request(KIND_DELETE, '1, '0, '0, '0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        insert_heavy = 1'b1;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 50; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 50; end
                default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) insert_heavy = (n == 0) ? 1'b1 : 1'($urandom_range(1));
                pending_requests.push_back(make_request(insert_heavy));
            end
            // back-pressure the output while the sender keeps offering items
            if (p == 0) hold_requests++;
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/stc_pkg.sv
hw/rtl/stc_ram.sv
hw/rtl/stc_ctrl.sv
hw/rtl/stc_dpath.sv
hw/rtl/symbol_table_cam.sv
dv/tb.sv
